// ===== hdl/integer_to_ascii_formatter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define ITOAF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITOAF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/itoaf_pkg.sv =====
// ----------------------------------------------------------------------------
// itoaf_pkg
// Shared types, widths and character codes of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoaf_pkg;

    localparam int OP_W       = 2;
    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 7;
    localparam int DIGITS_DEC = 20;
    localparam int DIGITS_HEX = VALUE_W / 4;
    localparam int BCD_W      = 4 * DIGITS_DEC;
    localparam int CNT_W      = $clog2(DIGITS_DEC + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam int QUEUE_DEPTH_DEF = 2;

    // format selectors
    localparam logic [OP_W-1:0] OP_SDEC     = 2'd0;
    localparam logic [OP_W-1:0] OP_UDEC     = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX      = 2'd2;
    localparam logic [OP_W-1:0] OP_HEX_ALT  = 2'd3;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;

    typedef struct packed {
        logic               hex;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } itoaf_job_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-4){1'b0}}, d};
        if (d > 4'd9)
            return CH_A + dx - 7'd10;
        else
            return CH_ZERO + dx;
    endfunction

endpackage

// ===== hdl/itoaf_if.sv =====
// ----------------------------------------------------------------------------
// itoaf_if
// Valid/ready channels of the formatter: value beats in, character beats out.
// ----------------------------------------------------------------------------
interface itoaf_cmd_if import itoaf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface itoaf_char_if import itoaf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== hdl/integer_to_ascii_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 64-bit value as signed decimal, unsigned decimal or 0x-prefixed
// hex ASCII text, one character per beat, newline last.
// ----------------------------------------------------------------------------
// Items are accepted into a queue of QUEUE_DEPTH entries and worked off one at
// a time. A decimal item is loaded, converted bit by bit with shift-and-add-3,
// has its leading zeros suppressed and is then sent one character at a time
// (sign, digits, newline). A hex item is loaded, sends the 0x prefix, skips its
// leading zeros, then sends its digits and the newline. A stalled consumer
// holds the single character output register and the sequence with it.
module integer_to_ascii_formatter_core import itoaf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    itoaf_cmd_if.sink    cmd,
    itoaf_char_if.source chars
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    itoaf_job_t front_job;
    itoaf_job_t back_job;

    itoaf_front u_front (
        .cmd  (cmd),
        .full (q_full),
        .push (q_push),
        .job  (front_job)
    );

    itoaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_job    (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_job    (back_job)
    );

    itoaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (back_job),
        .pop       (q_pop),
        .chars     (chars)
    );

endmodule

// ===== hdl/itoaf_front.sv =====
// ----------------------------------------------------------------------------
// itoaf_front
// Accepts value beats, picks the format and takes the magnitude of negatives.
// ----------------------------------------------------------------------------
module itoaf_front import itoaf_pkg::*;
(
    itoaf_cmd_if.sink  cmd,
    input  logic       full,
    output logic       push,
    output itoaf_job_t job
);

    logic is_neg;

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;

    always_comb
    begin
        job.hex = 1'b0;
        is_neg  = 1'b0;
        case (cmd.operation)
            OP_SDEC:    is_neg  = cmd.value[VALUE_W-1];
            OP_UDEC:    is_neg  = 1'b0;
            OP_HEX,
            OP_HEX_ALT: job.hex = 1'b1;
            default:    job.hex = 1'b1;
        endcase
        job.neg = is_neg;
        // two's complement negate; the most negative value maps onto itself
        job.mag = is_neg ? (VALUE_W'(0) - cmd.value) : cmd.value;
    end

endmodule

// ===== hdl/itoaf_queue.sv =====
// ----------------------------------------------------------------------------
// itoaf_queue
// Small FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module itoaf_queue import itoaf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  itoaf_job_t wr_job,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output itoaf_job_t rd_job
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    itoaf_job_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_job    = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== hdl/itoaf_back.sv =====
// ----------------------------------------------------------------------------
// itoaf_back
// Bit-serial binary to BCD conversion and character sequencer with an
// output register.
// ----------------------------------------------------------------------------
module itoaf_back import itoaf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    input  itoaf_job_t   job,
    output logic         pop,
    itoaf_char_if.source chars
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_PFX0  = 3'd2;
    localparam logic [2:0] S_PFXX  = 3'd3;
    localparam logic [2:0] S_MINUS = 3'd4;
    localparam logic [2:0] S_SKIP  = 3'd5;
    localparam logic [2:0] S_DIGIT = 3'd6;
    localparam logic [2:0] S_NL    = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     dig_reg, dig_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic                 ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]    ochar_reg, ochar_next;
    logic                 olast_reg, olast_next;

    logic                 slot_free;
    logic                 emit;
    logic [CHAR_W-1:0]    emit_char;
    logic                 emit_last;
    logic [3:0]           top_digit;

    // one shift-and-add-3 step: add 3 to every digit above 4, then shift in the next bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < DIGITS_DEC; i++)
        begin
            if (bcd[4*i +: 4] > 4'd4)
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    assign slot_free = !ovalid_reg || chars.ready;
    assign top_digit = dig_reg[BCD_W-1 -: 4];

    assign chars.valid     = ovalid_reg;
    assign chars.character = ochar_reg;
    assign chars.last      = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_char  = CH_NL;
        emit_last  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    if (job.hex)
                    begin
                        dig_next   = {job.mag, {(BCD_W-VALUE_W){1'b0}}};
                        cnt_next   = CNT_W'(DIGITS_HEX);
                        state_next = S_PFX0;
                    end
                    else
                    begin
                        bin_next   = job.mag;
                        dig_next   = '0;
                        bit_next   = '0;
                        neg_next   = job.neg;
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV:
            begin
                dig_next = dabble(dig_reg, bin_reg[VALUE_W-1]);
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    cnt_next   = CNT_W'(DIGITS_DEC);
                    state_next = neg_reg ? S_MINUS : S_SKIP;
                end
            end
            S_PFX0:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_ZERO;
                    state_next = S_PFXX;
                end
            end
            S_PFXX:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_X;
                    state_next = S_SKIP;
                end
            end
            S_MINUS:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_MINUS;
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, always keep the last digit
                if (top_digit == 4'd0 && cnt_reg > CNT_W'(1))
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                    state_next = S_DIGIT;
            end
            S_DIGIT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_char = digit_char(top_digit);
                    dig_next  = {dig_reg[BCD_W-5:0], 4'd0};
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_next = S_NL;
                end
            end
            S_NL:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_NL;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            ochar_next  = emit_char;
            olast_next  = emit_last;
        end
        else if (chars.ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        dig_reg   <= dig_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
        bit_reg   <= bit_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

endmodule

// ===== hdl/itoaf_checker.sv =====
// ----------------------------------------------------------------------------
// itoaf_checker
// Port-level checks on the character stream of the formatter.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_core_assert.svh"

module itoaf_checker import itoaf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] character,
    input logic              last
);

    `ITOAF_ASSERT_NXT(a_valid_holds, out_valid && !out_ready, out_valid, "valid dropped under stall")
    `ITOAF_ASSERT_NXT(a_beat_holds, out_valid && !out_ready, $stable(character) && $stable(last), "beat changed under stall")
    `ITOAF_ASSERT_IMP(a_last_is_nl, out_valid && last, character == CH_NL, "last beat is not a newline")
    `ITOAF_ASSERT_IMP(a_nl_is_last, out_valid && !last, character != CH_NL, "newline before end of text")

endmodule

bind integer_to_ascii_formatter_core itoaf_checker u_itoaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .character (chars.character),
    .last      (chars.last)
);
